FILE: sv/ilss_pkg.sv
// Shared constants, command codes and control types of the indexed list shift store.
`default_nettype none

package ilss_pkg;

   localparam int unsigned CMD_W   = 2;
   localparam int unsigned POS_W   = 6;
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned LEN_W   = 7;

   localparam int unsigned DEPTH_DEFAULT = 64;

   localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

   // read-select tree: first level picks within groups of GROUP entries
   localparam int unsigned GSEL_W  = 3;
   localparam int unsigned GROUP   = 2 ** GSEL_W;
   localparam int unsigned GRP_W   = POS_W - GSEL_W;
   localparam int unsigned NGROUPS = 2 ** GRP_W;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

   typedef struct packed {
      logic exec;
      logic load_out;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

FILE: sv/ilss_req_if.sv
// Request channel interface: valid/ready handshake with command, position and value.
`default_nettype none

interface ilss_req_if;
   logic                                     valid;
   logic                                     ready;
   logic        [ilss_pkg::CMD_W-1:0]        command;
   logic        [ilss_pkg::POS_W-1:0]        position;
   logic signed [ilss_pkg::DATA_W-1:0]       value;

   modport source (output valid, output command, output position, output value,
                   input ready);
   modport sink   (input valid, input command, input position, input value,
                   output ready);
endinterface

`default_nettype wire

FILE: sv/ilss_rsp_if.sv
// Response channel interface: valid/ready handshake with read value and index error.
`default_nettype none

interface ilss_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [ilss_pkg::DATA_W-1:0]       read_value;
   logic                                     index_error;

   modport source (output valid, output read_value, output index_error, input ready);
   modport sink   (input valid, input read_value, input index_error, output ready);
endinterface

`default_nettype wire

FILE: sv/ilss_datapath.sv
// Datapath: list register cells, length register, read-select tree and response registers.
`default_nettype none

module ilss_datapath #(
   parameter int unsigned DEPTH = ilss_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire ilss_pkg::ctrl_cmd_type              ctrl_cmd,
   input  wire logic                                csr_write_enable,
   input  wire logic        [ilss_pkg::LEN_W-1:0]   csr_write_data,
   input  wire logic        [ilss_pkg::CMD_W-1:0]   req_command,
   input  wire logic        [ilss_pkg::POS_W-1:0]   req_position,
   input  wire logic signed [ilss_pkg::DATA_W-1:0]  req_value,
   output logic signed      [ilss_pkg::DATA_W-1:0]  rsp_read_value,
   output logic                                     rsp_index_error
);

   localparam int unsigned LW = $clog2(DEPTH + 1);
   localparam int unsigned IW = (LW > ilss_pkg::LEN_W) ? LW : ilss_pkg::LEN_W;

   logic        [ilss_pkg::LEN_W-1:0]  length_ff;
   logic        [IW-1:0]               len_ext;
   logic        [IW-1:0]               eff_len;
   logic        [IW-1:0]               last_idx;
   logic        [IW-1:0]               pos_ext;
   logic                               in_range;

   logic signed [ilss_pkg::DATA_W-1:0] entry_ff [DEPTH];
   logic signed [ilss_pkg::DATA_W-1:0] entry_in [DEPTH];

   logic signed [ilss_pkg::DATA_W-1:0] pad_w    [ilss_pkg::NGROUPS][ilss_pkg::GROUP];
   logic signed [ilss_pkg::DATA_W-1:0] group_in [ilss_pkg::NGROUPS];
   logic signed [ilss_pkg::DATA_W-1:0] group_ff [ilss_pkg::NGROUPS];
   logic        [ilss_pkg::GRP_W-1:0]  pos_grp_ff;
   logic                               err_ff;

   logic signed [ilss_pkg::DATA_W-1:0] rsp_read_value_ff;
   logic                               rsp_index_error_ff;

   // length register, saturated to the depth
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= ilss_pkg::LEN_RESET;
      end else if (csr_write_enable) begin
         length_ff <= csr_write_data;
      end
   end

   always_comb begin
      len_ext  = IW'(length_ff);
      eff_len  = (len_ext > IW'(DEPTH)) ? IW'(DEPTH) : len_ext;
      last_idx = eff_len - IW'(1);
      pos_ext  = IW'(req_position);
      in_range = (pos_ext < eff_len);
   end

   // one cell per entry, each choosing among hold, its neighbors, zero and the new word
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [IW-1:0] IDX = IW'(i);
      logic signed [ilss_pkg::DATA_W-1:0] lower_w;
      logic signed [ilss_pkg::DATA_W-1:0] upper_w;

      if (i == 0) begin : g_lo0
         assign lower_w = '0;
      end else begin : g_lo
         assign lower_w = entry_ff[i-1];
      end
      if (i == DEPTH - 1) begin : g_hi0
         assign upper_w = '0;
      end else begin : g_hi
         assign upper_w = entry_ff[i+1];
      end

      always_comb begin
         entry_in[i] = entry_ff[i];
         if (in_range) begin
            case (req_command)
               ilss_pkg::CMD_INSERT: begin
                  if (IDX == pos_ext) begin
                     entry_in[i] = req_value;
                  end else if (IDX > pos_ext && IDX < eff_len) begin
                     entry_in[i] = lower_w;
                  end
               end
               ilss_pkg::CMD_UPDATE: begin
                  if (IDX == pos_ext) begin
                     entry_in[i] = req_value;
                  end
               end
               ilss_pkg::CMD_DELETE: begin
                  if (IDX >= pos_ext && IDX < last_idx) begin
                     entry_in[i] = upper_w;
                  end else if (IDX == last_idx) begin
                     entry_in[i] = '0;
                  end
               end
               default: begin
                  entry_in[i] = entry_ff[i];
               end
            endcase
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            entry_ff[i] <= '0;
         end else if (ctrl_cmd.exec) begin
            entry_ff[i] <= entry_in[i];
         end
      end
   end

   // entries beyond the depth read as zero
   for (genvar g = 0; g < ilss_pkg::NGROUPS; g++) begin : g_grp
      for (genvar k = 0; k < ilss_pkg::GROUP; k++) begin : g_pad
         if (g * ilss_pkg::GROUP + k < DEPTH) begin : g_used
            assign pad_w[g][k] = entry_ff[g * ilss_pkg::GROUP + k];
         end else begin : g_zero
            assign pad_w[g][k] = '0;
         end
      end
      assign group_in[g] = pad_w[g][req_position[ilss_pkg::GSEL_W-1:0]];
   end

   // first read level samples the old entries on the same edge the cells update
   always_ff @(posedge clock) begin
      if (ctrl_cmd.exec) begin
         group_ff   <= group_in;
         pos_grp_ff <= req_position[ilss_pkg::POS_W-1:ilss_pkg::GSEL_W];
         err_ff     <= !in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.load_out) begin
         rsp_read_value_ff  <= err_ff ? '0 : group_ff[pos_grp_ff];
         rsp_index_error_ff <= err_ff;
      end
   end

   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_index_error = rsp_index_error_ff;

endmodule

`default_nettype wire

FILE: sv/ilss_ctrl.sv
// Controller: request acceptance, response load sequencing and response valid register.
`default_nettype none

module ilss_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output ilss_pkg::ctrl_cmd_type       ctrl_cmd
);

   localparam int unsigned STATE_W = 1;
   localparam logic [STATE_W-1:0] S_IDLE = 1'b0;
   localparam logic [STATE_W-1:0] S_SEL  = 1'b1;

   logic [STATE_W-1:0] state_ff;
   logic [STATE_W-1:0] state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in          = state_ff;
      ctrl_cmd.exec     = 1'b0;
      ctrl_cmd.load_out = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl_cmd.exec = 1'b1;
               state_in      = S_SEL;
            end
         end
         S_SEL: begin
            if (out_free) begin
               ctrl_cmd.load_out = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (ctrl_cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_exec_to_sel: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.exec |=> (state_ff == S_SEL))
      else $error("accepted request did not move to select");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.load_out |=> rsp_valid_ff)
      else $error("response load did not raise valid");

   a_sel_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEL && rsp_valid_ff && !rsp_ready) |=> (state_ff == S_SEL))
      else $error("pending response overwritten while stalled");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ctrl_cmd.exec && ctrl_cmd.load_out))
      else $error("execute and load issued together");
`endif

endmodule

`default_nettype wire

FILE: sv/indexed_list_shift_store.sv
// Top level of the indexed list shift store: channels, length register port and submodules.
`default_nettype none

// Indexed list shift store. Holds DEPTH signed 32-bit entries as a row of register
// cells, of which the first list_length (written on csr_write_data, saturated to DEPTH,
// reset value 64) are in use. Each request carries a command (insert, update, delete,
// read), a position and a value, and yields exactly one response: the entry at that
// position before the command, or index_error with a zero value when the position is
// not below the length in use, in which case nothing changes. Insert moves the used
// entries above the position up one place and drops the last one; delete moves them
// down and writes zero into the last used place. All cells shift together on the edge
// that accepts the request. The cells and the first level of the read-select tree load
// on the accept edge; the second level then loads the response register from the select
// step once the output register is free. A new request is taken only after the last one
// has loaded its response register; a response left waiting holds the request in flight
// at the select step, and no new request is taken until it drains. Reset clears every
// cell at once, so requests are taken as soon as reset is released. Write the length
// only while idle.
module indexed_list_shift_store #(
   parameter int unsigned DEPTH = ilss_pkg::DEPTH_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   ilss_req_if.sink                         req_if,
   ilss_rsp_if.source                       rsp_if,
   input  wire logic                        csr_write_enable,
   input  wire logic [ilss_pkg::LEN_W-1:0]  csr_write_data
);

   ilss_pkg::ctrl_cmd_type ctrl_cmd;

   // sequence: accept and execute, then load the response register
   ilss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .ctrl_cmd  (ctrl_cmd)
   );

   // hold the cells, advance them on execute, select the old entry for the response
   ilss_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl_cmd         (ctrl_cmd),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_command      (req_if.command),
      .req_position     (req_if.position),
      .req_value        (req_if.value),
      .rsp_read_value   (rsp_if.read_value),
      .rsp_index_error  (rsp_if.index_error)
   );

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the indexed list shift store, checked against a list shadow.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LIST_DEPTH  = ilss_pkg::DEPTH_DEFAULT;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned PHASE_ITEMS = 108;

   typedef struct {
      logic [ilss_pkg::CMD_W-1:0]         command;
      logic [ilss_pkg::POS_W-1:0]         position;
      logic signed [ilss_pkg::DATA_W-1:0] value;
      bit                                 drain_first;   // hold until every response is back
   } list_request_type;

   typedef struct {
      logic signed [ilss_pkg::DATA_W-1:0] read_value;
      logic                               index_error;
   } list_response_type;

   typedef enum int {
      STALL_NONE,
      STALL_COIN,
      STALL_EVERY_FOURTH,
      STALL_LONG
   } stall_mode_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [ilss_pkg::LEN_W-1:0] csr_write_data;

   ilss_req_if req_chan ();
   ilss_rsp_if rsp_chan ();

   indexed_list_shift_store #(
      .DEPTH(LIST_DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_chan),
      .rsp_if           (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the list and of the length register.
   logic signed [ilss_pkg::DATA_W-1:0] list_shadow [LIST_DEPTH];
   logic [ilss_pkg::LEN_W-1:0]         length_shadow;

   list_request_type  pending_requests[$];
   list_response_type expected_responses[$];
   int                mismatch_count = 0;

   // Sender burst state, touched only by the driver.
   int burst_left = 0;
   int gap_left   = 0;

   // Receiver stall state, touched only by the monitor.
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left  = 0;
   int             hold_left  = 0;
   int             beat_count = 0;

   int idle_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Work out the response to one accepted request and apply it to the shadow list.
   function automatic void apply_list_command(
      input logic [ilss_pkg::CMD_W-1:0]         command,
      input logic [ilss_pkg::POS_W-1:0]         position,
      input logic signed [ilss_pkg::DATA_W-1:0] value);
      int unsigned       used_len;
      int                i;
      list_response_type rsp;
      used_len = (length_shadow > LIST_DEPTH) ? LIST_DEPTH : length_shadow;
      if (position >= used_len) begin
         // Out of range: zero value, error flag, list untouched.
         rsp.read_value  = '0;
         rsp.index_error = 1'b1;
      end else begin
         rsp.read_value  = list_shadow[position];
         rsp.index_error = 1'b0;
         case (command)
            ilss_pkg::CMD_INSERT: begin
               // Shift the used tail up and drop the last used entry.
               for (i = int'(used_len) - 1; i > int'(position); i--)
                  list_shadow[i] = list_shadow[i-1];
               list_shadow[position] = value;
            end
            ilss_pkg::CMD_UPDATE: begin
               list_shadow[position] = value;
            end
            ilss_pkg::CMD_DELETE: begin
               // Shift the used tail down and zero the last used place.
               for (i = int'(position); i + 1 < int'(used_len); i++)
                  list_shadow[i] = list_shadow[i+1];
               list_shadow[used_len-1] = '0;
            end
            default: ;
         endcase
      end
      expected_responses.push_back(rsp);
   endfunction

   function automatic void queue_request(
      input logic [ilss_pkg::CMD_W-1:0]         command,
      input logic [ilss_pkg::POS_W-1:0]         position,
      input logic signed [ilss_pkg::DATA_W-1:0] value,
      input bit                                 drain_first);
      list_request_type req;
      req.command     = command;
      req.position    = position;
      req.value       = value;
      req.drain_first = drain_first;
      pending_requests.push_back(req);
   endfunction

   // Build a random request, biased toward positions that the length in use accepts.
   function automatic list_request_type random_request(input int unsigned used_len);
      list_request_type req;
      int unsigned      pick;
      req.command     = ilss_pkg::CMD_W'($urandom_range(0, 3));
      req.drain_first = 1'b0;
      pick = $urandom_range(0, 99);
      if (used_len == 0 || pick >= 86)
         req.position = ilss_pkg::POS_W'($urandom_range(0, LIST_DEPTH - 1));
      else if (pick < 70)
         req.position = ilss_pkg::POS_W'($urandom_range(0, used_len - 1));
      else if (pick < 78)
         req.position = ($urandom_range(0, 1) != 0) ? ilss_pkg::POS_W'(used_len - 1) : '0;
      else
         req.position = (used_len < LIST_DEPTH) ? ilss_pkg::POS_W'(used_len) :
                                                  ilss_pkg::POS_W'(LIST_DEPTH - 1);
      pick = $urandom_range(0, 19);
      case (pick)
         0:       req.value = 32'sh7FFF_FFFF;
         1:       req.value = 32'sh8000_0000;
         2:       req.value = '0;
         3:       req.value = -32'sd1;
         default: req.value = $urandom;
      endcase
      return req;
   endfunction

   // Block until nothing is queued, nothing is on the request channel and every
   // response is back. Sample after the edge so the driver's updates have settled.
   task automatic wait_until_idle();
      @(posedge clock);
      #1;
      while (pending_requests.size() != 0 || req_chan.valid || expected_responses.size() != 0)
      begin
         @(posedge clock);
         #1;
      end
   endtask

   // Write the length register while the block is idle.
   task automatic set_list_length(input logic [ilss_pkg::LEN_W-1:0] new_len);
      wait_until_idle();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= new_len;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      length_shadow = new_len;
   endtask

   // Driver: advance to the next request once the current one is taken, in bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            apply_list_command(req_chan.command, req_chan.position, req_chan.value);
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (pending_requests.size() != 0 &&
                         !(pending_requests[0].drain_first &&
                           expected_responses.size() != 0)) begin
               list_request_type req;
               req = pending_requests.pop_front();
               req_chan.command  <= req.command;
               req_chan.position <= req.position;
               req_chan.value    <= req.value;
               req_chan.valid    <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // Close the burst: sometimes run straight on, otherwise idle a while.
                  burst_left = $urandom_range(1, 30);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each response against the oldest expectation, stall on its own pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_responses.size() == 0) begin
               $error("response with no request outstanding: read_value %0d index_error %0b",
                      rsp_chan.read_value, rsp_chan.index_error);
               mismatch_count++;
            end else begin
               list_response_type exp_rsp;
               exp_rsp = expected_responses.pop_front();
               if (rsp_chan.read_value !== exp_rsp.read_value) begin
                  $error("read_value mismatch: expected %0d, actual %0d",
                         exp_rsp.read_value, rsp_chan.read_value);
                  mismatch_count++;
               end
               if (rsp_chan.index_error !== exp_rsp.index_error) begin
                  $error("index_error mismatch: expected %0b, actual %0b",
                         exp_rsp.index_error, rsp_chan.index_error);
                  mismatch_count++;
               end
            end
         end
         // Pick a new stall mode every so often.
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 120);
         end
         mode_left--;
         beat_count++;
         case (stall_mode)
            STALL_NONE:         rsp_chan.ready <= 1'b1;
            STALL_COIN:         rsp_chan.ready <= ($urandom_range(0, 1) != 0);
            STALL_EVERY_FOURTH: rsp_chan.ready <= (beat_count % 4 == 3);
            STALL_LONG: begin
               if (hold_left > 0) begin
                  hold_left--;
                  rsp_chan.ready <= 1'b0;
               end else begin
                  hold_left = $urandom_range(0, 20);
                  rsp_chan.ready <= 1'b1;
               end
            end
            default:            rsp_chan.ready <= 1'b1;
         endcase
      end
   end

   // Watchdog: drop the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          csr_write_enable) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus: directed corners first, then random phases over a range of lengths.
   initial begin
      int unsigned      phase_lengths[14];
      int unsigned      used_len;
      int unsigned      count;
      list_request_type req;

      phase_lengths    = '{64, 2, 1, 37, 127, 0, 64, 9, 65, 100, 3, 48, 64, 16};
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_chan.valid    = 1'b0;
      req_chan.command  = ilss_pkg::CMD_READ;
      req_chan.position = '0;
      req_chan.value    = '0;
      rsp_chan.ready    = 1'b0;
      length_shadow     = ilss_pkg::LEN_RESET;
      foreach (list_shadow[i])
         list_shadow[i] = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset length, cleared store: read both ends, then hit each command at the extremes.
      queue_request(ilss_pkg::CMD_READ,   6'd0,  '0, 1'b0);
      queue_request(ilss_pkg::CMD_READ,   6'd63, '0, 1'b0);
      queue_request(ilss_pkg::CMD_INSERT, 6'd0,  32'sh7FFF_FFFF, 1'b0);
      queue_request(ilss_pkg::CMD_INSERT, 6'd63, 32'sh8000_0000, 1'b0);
      queue_request(ilss_pkg::CMD_INSERT, 6'd5,  -32'sd1, 1'b0);
      queue_request(ilss_pkg::CMD_UPDATE, 6'd63, 32'sh5555_5555, 1'b0);
      queue_request(ilss_pkg::CMD_UPDATE, 6'd0,  32'shAAAA_AAAA, 1'b0);
      queue_request(ilss_pkg::CMD_READ,   6'd5,  '0, 1'b0);
      queue_request(ilss_pkg::CMD_DELETE, 6'd0,  '0, 1'b0);
      queue_request(ilss_pkg::CMD_DELETE, 6'd63, '0, 1'b0);
      queue_request(ilss_pkg::CMD_DELETE, 6'd10, '0, 1'b0);
      queue_request(ilss_pkg::CMD_READ,   6'd62, '0, 1'b0);
      queue_request(ilss_pkg::CMD_READ,   6'd63, '0, 1'b0);

      // Zero length: every command must report an index error.
      set_list_length(7'd0);
      queue_request(ilss_pkg::CMD_INSERT, 6'd0,  32'sd1, 1'b0);
      queue_request(ilss_pkg::CMD_UPDATE, 6'd0,  32'sd2, 1'b0);
      queue_request(ilss_pkg::CMD_DELETE, 6'd0,  '0, 1'b0);
      queue_request(ilss_pkg::CMD_READ,   6'd0,  '0, 1'b0);
      queue_request(ilss_pkg::CMD_READ,   6'd63, '0, 1'b0);

      // Length above depth saturates: the top entry is still in use.
      set_list_length(7'd127);
      queue_request(ilss_pkg::CMD_INSERT, 6'd63, 32'sd123, 1'b0);
      queue_request(ilss_pkg::CMD_READ,   6'd63, '0, 1'b0);

      // Single entry: only position zero works; entries above it stay put.
      set_list_length(7'd1);
      queue_request(ilss_pkg::CMD_INSERT, 6'd0, 32'sh8000_0000, 1'b0);
      queue_request(ilss_pkg::CMD_READ,   6'd1, '0, 1'b0);
      queue_request(ilss_pkg::CMD_DELETE, 6'd0, '0, 1'b0);
      queue_request(ilss_pkg::CMD_READ,   6'd0, '0, 1'b0);

      // Random phases, each under its own length setting.
      foreach (phase_lengths[p]) begin
         set_list_length(ilss_pkg::LEN_W'(phase_lengths[p]));
         used_len = (phase_lengths[p] > LIST_DEPTH) ? LIST_DEPTH : phase_lengths[p];
         count    = (used_len == 0) ? 25 : PHASE_ITEMS;
         for (int n = 0; n < count; n++) begin
            req = random_request(used_len);
            // Hold the sender once per nonzero-length phase until the response queue drains.
            if (n == 55)
               req.drain_first = 1'b1;
            pending_requests.push_back(req);
         end
      end

      wait_until_idle();
      repeat (6) @(posedge clock);
      if (mismatch_count == 0 && expected_responses.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
